/* rtl/core/pps_pkg.sv */
// Shared types, opcodes and default sizes for the preemptive priority scheduler.
`default_nettype none

package pps_pkg;

    // Default sizing
    localparam int MAX_TASKS_DEF = 16;
    localparam int TIME_BITS_DEF = 16;

    // Request opcodes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Request transaction
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] arrival_time;
        logic [7:0]  priority_req;
        logic [15:0] burst_time;
    } req_t;

    // Response transaction
    typedef struct packed {
        logic [3:0]  ran_slot;
        logic        idle;
        logic        first_run;
        logic        finished;
        logic [15:0] completion_time;
        logic [15:0] turnaround_time;
        logic [15:0] waiting_time;
        logic [15:0] response_time;
        logic        all_done;
    } rsp_t;

    // One task table entry
    typedef struct packed {
        logic [15:0] arrival;
        logic [7:0]  prio;
        logic [15:0] remaining;
        logic [15:0] initial_burst;
        logic [15:0] response;
    } entry_t;

endpackage

`default_nettype wire

/* rtl/core/preemptive_priority_scheduler.sv */
// Top level: task table memory, sequencer and response output register.
// Load and clear transactions give no response.
// A tick passes from acceptance to rsp_valid through a scan that reads each loaded slot,
// the memory read register, the update state, the emit state and then the output register.
// An empty table skips the scan. No new request is taken until the response leaves emit.
// Reset (rst_n, asynchronous, active low) empties the table and zeroes the time counter.
`default_nettype none

module preemptive_priority_scheduler #(
    parameter int MAX_TASKS = pps_pkg::MAX_TASKS_DEF,
    parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire pps_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output pps_pkg::rsp_t      rsp
);

    localparam int SLOT_W = $clog2(MAX_TASKS);

    logic                  res_valid;
    logic                  res_ready;
    pps_pkg::rsp_t         res;
    logic                  mem_wr_en;
    logic [SLOT_W-1:0]     mem_wr_addr;
    pps_pkg::entry_t       mem_wr_data;
    logic                  mem_rd_en;
    logic [SLOT_W-1:0]     mem_rd_addr;
    pps_pkg::entry_t       mem_rd_data;
    logic                  out_valid_reg;
    pps_pkg::rsp_t         out_reg;

    pps_task_mem #(
        .DEPTH  (MAX_TASKS),
        .ADDR_W (SLOT_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    pps_ctrl #(
        .MAX_TASKS (MAX_TASKS),
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // Output register: free when empty or being drained this cycle
    assign res_ready = !out_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire

/* rtl/core/pps_task_mem.sv */
// Task table: single write port, single read port, registered read data.
`default_nettype none

module pps_task_mem #(
    parameter int DEPTH  = pps_pkg::MAX_TASKS_DEF,
    parameter int ADDR_W = $clog2(pps_pkg::MAX_TASKS_DEF)
) (
    input  wire logic                  clk,
    input  wire logic                  wr_en,
    input  wire logic [ADDR_W-1:0]     wr_addr,
    input  wire pps_pkg::entry_t       wr_data,
    input  wire logic                  rd_en,
    input  wire logic [ADDR_W-1:0]     rd_addr,
    output pps_pkg::entry_t            rd_data
);

    pps_pkg::entry_t mem [DEPTH];
    pps_pkg::entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/core/pps_ctrl.sv */
// Scheduler sequencer: load, clear, scan for the winner, update the entry, build the response.
`default_nettype none

module pps_ctrl #(
    parameter int MAX_TASKS = pps_pkg::MAX_TASKS_DEF,
    parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_ready,
    input  wire pps_pkg::req_t                  req,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output pps_pkg::rsp_t                       res,
    output logic                                mem_wr_en,
    output logic [$clog2(MAX_TASKS)-1:0]        mem_wr_addr,
    output pps_pkg::entry_t                     mem_wr_data,
    output logic                                mem_rd_en,
    output logic [$clog2(MAX_TASKS)-1:0]        mem_rd_addr,
    input  wire pps_pkg::entry_t                mem_rd_data
);

    localparam int SLOT_W = $clog2(MAX_TASKS);
    localparam int CW     = $clog2(MAX_TASKS + 1);
    localparam int W      = (TIME_BITS > 16) ? TIME_BITS : 16;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    logic [1:0]           state_reg,     state_next;
    logic [CW-1:0]        count_reg,     count_next;
    logic [TIME_BITS-1:0] time_reg,      time_next;
    logic [MAX_TASKS-1:0] started_reg,   started_next;
    logic [MAX_TASKS-1:0] done_reg,      done_next;
    logic [CW-1:0]        issue_reg,     issue_next;
    logic                 rd_vld_reg;
    logic [SLOT_W-1:0]    rd_slot_reg;
    logic                 best_vld_reg,  best_vld_next;
    logic [SLOT_W-1:0]    best_slot_reg, best_slot_next;
    pps_pkg::entry_t      best_reg,      best_next;
    pps_pkg::rsp_t        res_reg,       res_next;

    logic                 accept;
    logic                 is_load;
    logic                 is_tick;
    logic                 is_clear;
    logic                 table_full;
    logic                 cand_ok;
    logic                 cand_better;
    logic                 scan_last;
    logic [W-1:0]         t0_w;
    logic [TIME_BITS-1:0] t_new;
    logic [W-1:0]         t_new_w;
    logic [W-1:0]         arr_w;
    logic [W-1:0]         resp_w;
    logic [W-1:0]         tat_w;
    logic [W-1:0]         wait_w;
    logic                 first;
    logic [15:0]          rem_new;
    logic                 fin;
    logic [15:0]          resp_out;
    logic [MAX_TASKS-1:0] done_after;
    logic                 every_done;
    pps_pkg::entry_t      upd_entry;

    assign accept     = req_valid && req_ready;
    assign is_load    = (req.op == pps_pkg::OP_LOAD);
    assign is_tick    = (req.op == pps_pkg::OP_TICK);
    assign is_clear   = (req.op == pps_pkg::OP_CLEAR);
    assign table_full = (count_reg == CW'(MAX_TASKS));
    assign req_ready  = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_EMIT);
    assign res        = res_reg;

    // Scan read issue
    assign mem_rd_en   = (state_reg == S_SCAN) && (issue_reg < count_reg);
    assign mem_rd_addr = issue_reg[SLOT_W-1:0];
    assign scan_last   = rd_vld_reg && ((CW'(rd_slot_reg) + CW'(1)) == count_reg);

    // Candidate compare against the current best
    assign cand_ok     = !done_reg[rd_slot_reg] && (W'(mem_rd_data.arrival) <= t0_w);
    assign cand_better = !best_vld_reg
                      || (mem_rd_data.prio < best_reg.prio)
                      || ((mem_rd_data.prio == best_reg.prio)
                          && (mem_rd_data.arrival < best_reg.arrival));

    // Time arithmetic for the winner
    assign t0_w    = W'(time_reg);
    assign t_new   = (time_reg != {TIME_BITS{1'b1}}) ? (time_reg + TIME_BITS'(1)) : time_reg;
    assign t_new_w = W'(t_new);
    assign arr_w   = W'(best_reg.arrival);
    assign resp_w  = (t0_w > arr_w) ? (t0_w - arr_w) : '0;
    assign tat_w   = (t_new_w > arr_w) ? (t_new_w - arr_w) : '0;
    assign wait_w  = (tat_w > W'(best_reg.initial_burst))
                   ? (tat_w - W'(best_reg.initial_burst)) : '0;
    assign first   = !started_reg[best_slot_reg];
    assign rem_new = (best_reg.remaining != 16'd0) ? (best_reg.remaining - 16'd1) : 16'd0;
    assign fin     = (rem_new == 16'd0);
    assign resp_out = first ? 16'(resp_w) : best_reg.response;

    // Done vector after this tick, then the all-finished check
    always_comb
    begin
        done_after = done_reg;
        if (best_vld_reg && fin)
        begin
            done_after[best_slot_reg] = 1'b1;
        end
        every_done = 1'b1;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            if (!done_after[i] && (CW'(i) < count_reg))
            begin
                every_done = 1'b0;
            end
        end
    end

    // Updated entry for the winner
    always_comb
    begin
        upd_entry           = best_reg;
        upd_entry.remaining = rem_new;
        upd_entry.response  = resp_out;
    end

    // Memory write: loads in idle, winner write-back in update
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = count_reg[SLOT_W-1:0];
        mem_wr_data = upd_entry;
        if (state_reg == S_IDLE)
        begin
            mem_wr_en                 = accept && is_load && !table_full;
            mem_wr_data.arrival       = req.arrival_time;
            mem_wr_data.prio          = req.priority_req;
            mem_wr_data.remaining     = req.burst_time;
            mem_wr_data.initial_burst = req.burst_time;
            mem_wr_data.response      = 16'd0;
        end
        else if (state_reg == S_UPDATE)
        begin
            mem_wr_en   = best_vld_reg;
            mem_wr_addr = best_slot_reg;
        end
    end

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        time_next      = time_reg;
        started_next   = started_reg;
        done_next      = done_reg;
        issue_next     = issue_reg;
        best_vld_next  = best_vld_reg;
        best_slot_next = best_slot_reg;
        best_next      = best_reg;
        res_next       = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (is_load && !table_full)
                    begin
                        started_next[count_reg[SLOT_W-1:0]] = 1'b0;
                        done_next[count_reg[SLOT_W-1:0]]    = (req.burst_time == 16'd0);
                        count_next                          = count_reg + CW'(1);
                    end
                    else if (is_clear)
                    begin
                        count_next   = '0;
                        time_next    = '0;
                        started_next = '0;
                        done_next    = '0;
                    end
                    else if (is_tick)
                    begin
                        issue_next    = '0;
                        best_vld_next = 1'b0;
                        state_next    = (count_reg == '0) ? S_UPDATE : S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (mem_rd_en)
                begin
                    issue_next = issue_reg + CW'(1);
                end
                if (rd_vld_reg && cand_ok && cand_better)
                begin
                    best_vld_next  = 1'b1;
                    best_slot_next = rd_slot_reg;
                    best_next      = mem_rd_data;
                end
                if (scan_last)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                time_next                = t_new;
                res_next                 = '0;
                res_next.completion_time = 16'(t_new_w);
                res_next.all_done        = every_done;
                if (best_vld_reg)
                begin
                    res_next.ran_slot  = 4'(best_slot_reg);
                    res_next.first_run = first;
                    res_next.finished  = fin;
                    if (first || fin)
                    begin
                        res_next.response_time = resp_out;
                    end
                    if (fin)
                    begin
                        res_next.turnaround_time = 16'(tat_w);
                        res_next.waiting_time    = 16'(wait_w);
                    end
                    started_next[best_slot_reg] = 1'b1;
                    done_next                   = done_after;
                end
                else
                begin
                    res_next.idle = 1'b1;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            time_reg     <= '0;
            started_reg  <= '0;
            done_reg     <= '0;
            issue_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            best_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            time_reg     <= time_next;
            started_reg  <= started_next;
            done_reg     <= done_next;
            issue_reg    <= issue_next;
            rd_vld_reg   <= mem_rd_en;
            best_vld_reg <= best_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_slot_reg   <= mem_rd_addr;
        best_slot_reg <= best_slot_next;
        best_reg      <= best_next;
        res_reg       <= res_next;
    end

endmodule

`default_nettype wire

/* rtl/core/pps_checker.sv */
// Port-level checker for the scheduler, bound to the top level.
`default_nettype none

module pps_port_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_ready,
    input wire pps_pkg::req_t req,
    input wire logic          rsp_valid,
    input wire logic          rsp_ready,
    input wire pps_pkg::rsp_t rsp
);

    // A stalled response holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

    // A tick occupies the sequencer: no request taken in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.op == pps_pkg::OP_TICK) |=> !req_ready)
    else $error("request accepted straight after a tick");

    // An idle tick runs nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.idle |-> !rsp.first_run && !rsp.finished && (rsp.ran_slot == 4'd0))
    else $error("idle tick reports a running task");

    // Waiting time never exceeds turnaround on completion
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.finished |-> rsp.waiting_time <= rsp.turnaround_time)
    else $error("waiting time above turnaround");

endmodule

bind preemptive_priority_scheduler pps_port_checker u_pps_checker (.*);

`default_nettype wire

/* tb/pps_checker.sv */
// Scoreboard for the priority scheduler: predicts tick responses and compares them.
`default_nettype none

module pps_checker
    import pps_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    input  wire logic req_ready,
    input  wire req_t req,
    input  wire logic rsp_valid,
    input  wire logic rsp_ready,
    input  wire rsp_t rsp,
    output int        mismatches,
    output int        outstanding,
    output int        responses_seen,
    output int        completions,
    output int        idle_ticks
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = MAX_TASKS_DEF;
    localparam logic [15:0] TIME_CEIL = 16'hFFFF;

    // Shadow copy of the task table
    logic [15:0] arrival_tbl [SLOTS];
    logic [7:0]  prio_tbl    [SLOTS];
    logic [15:0] left_tbl    [SLOTS];
    logic [15:0] burst_tbl   [SLOTS];
    logic [15:0] resp_tbl    [SLOTS];
    bit          started_tbl [SLOTS];
    bit          done_tbl    [SLOTS];
    int unsigned n_loaded;
    logic [15:0] now_time;

    // Responses still owed by the block, oldest first
    rsp_t tick_results_due[$];

    int n_bad;
    int n_rsp;
    int n_fin;
    int n_idle;

    function automatic void clear_table();
        for (int i = 0; i < SLOTS; i++)
        begin
            arrival_tbl[i] = '0;
            prio_tbl[i]    = '0;
            left_tbl[i]    = '0;
            burst_tbl[i]   = '0;
            resp_tbl[i]    = '0;
            started_tbl[i] = 1'b0;
            done_tbl[i]    = 1'b0;
        end
        n_loaded = 0;
        now_time = '0;
    endfunction

    // Apply one request to the shadow table; returns 1 when a response is due
    function automatic bit schedule_step(input req_t r, output rsp_t res);
        int          pick;
        logic [15:0] t0;
        logic [15:0] tat;
        bit          every_fin;
        res  = '0;
        pick = -1;
        case (r.op)
            OP_CLEAR:
            begin
                clear_table();
                return 1'b0;
            end
            OP_LOAD:
            begin
                // loads beyond capacity are dropped
                if (n_loaded < SLOTS)
                begin
                    arrival_tbl[n_loaded] = r.arrival_time;
                    prio_tbl[n_loaded]    = r.priority_req;
                    left_tbl[n_loaded]    = r.burst_time;
                    burst_tbl[n_loaded]   = r.burst_time;
                    resp_tbl[n_loaded]    = '0;
                    started_tbl[n_loaded] = 1'b0;
                    done_tbl[n_loaded]    = (r.burst_time == 16'd0);
                    n_loaded++;
                end
                return 1'b0;
            end
            OP_TICK: ;
            default: return 1'b0;
        endcase

        // Pick the best arrived, unfinished task; strict compares keep the lowest slot
        t0 = now_time;
        for (int i = 0; i < n_loaded; i++)
        begin
            if (done_tbl[i] || arrival_tbl[i] > t0)
                continue;
            if (pick < 0 || prio_tbl[i] < prio_tbl[pick] ||
                (prio_tbl[i] == prio_tbl[pick] && arrival_tbl[i] < arrival_tbl[pick]))
                pick = i;
        end

        // time saturates at its ceiling
        now_time = (t0 != TIME_CEIL) ? t0 + 16'd1 : TIME_CEIL;
        res.completion_time = now_time;

        if (pick < 0)
            res.idle = 1'b1;
        else
        begin
            res.ran_slot = 4'(pick);
            if (!started_tbl[pick])
            begin
                started_tbl[pick] = 1'b1;
                resp_tbl[pick]    = (t0 > arrival_tbl[pick]) ? t0 - arrival_tbl[pick] : 16'd0;
                res.first_run     = 1'b1;
                res.response_time = resp_tbl[pick];
            end
            if (left_tbl[pick] != 16'd0)
                left_tbl[pick] = left_tbl[pick] - 16'd1;
            if (left_tbl[pick] == 16'd0)
            begin
                tat = (now_time > arrival_tbl[pick]) ? now_time - arrival_tbl[pick] : 16'd0;
                done_tbl[pick]      = 1'b1;
                res.finished        = 1'b1;
                res.turnaround_time = tat;
                res.waiting_time    = (tat > burst_tbl[pick]) ? tat - burst_tbl[pick] : 16'd0;
                res.response_time   = resp_tbl[pick];
            end
        end

        every_fin = 1'b1;
        for (int i = 0; i < n_loaded; i++)
            if (!done_tbl[i])
                every_fin = 1'b0;
        res.all_done = every_fin;
        return 1'b1;
    endfunction

    function automatic void check_field(string fname, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            n_bad++;
            if (n_bad <= 10)
                $display("response %0d: %s mismatch, expected %h, got %h",
                         n_rsp, fname, want, got);
        end
    endfunction

    // Response side is handled before the request side so a fresh request
    // can never pair with a response accepted at the same edge
    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        rsp_t want;
        rsp_t due;
        if (!rst_n)
        begin
            clear_table();
            tick_results_due.delete();
            n_bad  = 0;
            n_rsp  = 0;
            n_fin  = 0;
            n_idle = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                n_rsp++;
                if (tick_results_due.size() == 0)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("response %0d arrived with nothing owed: %p", n_rsp, rsp);
                end
                else
                begin
                    want = tick_results_due.pop_front();
                    check_field("ran_slot",        16'(want.ran_slot),  16'(rsp.ran_slot));
                    check_field("idle",            16'(want.idle),      16'(rsp.idle));
                    check_field("first_run",       16'(want.first_run), 16'(rsp.first_run));
                    check_field("finished",        16'(want.finished),  16'(rsp.finished));
                    check_field("completion_time", want.completion_time, rsp.completion_time);
                    check_field("turnaround_time", want.turnaround_time, rsp.turnaround_time);
                    check_field("waiting_time",    want.waiting_time,    rsp.waiting_time);
                    check_field("response_time",   want.response_time,   rsp.response_time);
                    check_field("all_done",        16'(want.all_done),  16'(rsp.all_done));
                    if (want.finished)
                        n_fin++;
                    if (want.idle)
                        n_idle++;
                end
            end
            if (req_valid && req_ready)
                if (schedule_step(req, due))
                    tick_results_due.push_back(due);
        end
        mismatches     <= n_bad;
        outstanding    <= tick_results_due.size();
        responses_seen <= n_rsp;
        completions    <= n_fin;
        idle_ticks     <= n_idle;
    end

endmodule

`default_nettype wire

/* tb/preemptive_priority_scheduler_tb.sv */
// Top of the scheduler testbench: clock, reset, request/response traffic and verdict.
`default_nettype none

module preemptive_priority_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pps_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         QUIET_LIMIT = 4000;
    localparam int         STALL_LEN   = 400;
    localparam int         PHASE_ITEMS = 270;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_ready = 1'b0;
    req_t req       = '0;
    logic req_ready;
    logic rsp_valid;
    rsp_t rsp;

    int mismatches;
    int outstanding;
    int responses_seen;
    int completions;
    int idle_ticks;

    int send_gap     = 12;
    int recv_gap     = 79;
    bit stall_armed  = 1'b0;
    int stall_cycles = 0;
    int items_sent   = 0;
    int quiet_cycles = 0;

    always #4 clk = ~clk;

    preemptive_priority_scheduler DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    pps_checker u_sched_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp            (rsp),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .responses_seen (responses_seen),
        .completions    (completions),
        .idle_ticks     (idle_ticks)
    );

    // Receiver: one long hold-off when armed, otherwise random back-pressure
    always @(negedge clk)
    begin
        if (stall_armed && stall_cycles < STALL_LEN)
        begin
            rsp_ready    <= 1'b0;
            stall_cycles <= stall_cycles + 1;
        end
        else
            rsp_ready <= ($urandom_range(99) >= recv_gap);
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("no transaction for %0d cycles, %0d responses still owed",
                         QUIET_LIMIT, outstanding);
                $display("preemptive_priority_scheduler_tb: FAIL");
                $finish;
            end
        end
    end

    // Offer one request, with random sender gaps, and hold it until accepted
    task automatic send_req(input logic [1:0] op, input logic [15:0] arr,
                            input logic [7:0] prio, input logic [15:0] burst);
        req_t item;
        item.op           = op;
        item.arrival_time = arr;
        item.priority_req = prio;
        item.burst_time   = burst;
        @(negedge clk);
        while ($urandom_range(99) < send_gap)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    task automatic tick();
        send_req(OP_TICK, 16'($urandom), 8'($urandom), 16'($urandom));
    endtask

    // Clear, load a random task set, then tick it through with some noise mixed in
    task automatic run_schedule_batch();
        int          n_tasks;
        int          budget;
        int          sel;
        logic [15:0] arr;
        logic [15:0] burst;
        logic [7:0]  prio;
        n_tasks = ($urandom_range(7) == 0) ? $urandom_range(16, 19) : $urandom_range(1, 6);
        budget  = 12;
        send_req(OP_CLEAR, 16'($urandom), 8'($urandom), 16'($urandom));
        for (int i = 0; i < n_tasks; i++)
        begin
            sel = $urandom_range(19);
            arr = (sel == 0) ? 16'($urandom) : (sel == 1) ? 16'hFFFF : 16'($urandom_range(0, 10));
            prio = $urandom_range(1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
            sel = $urandom_range(39);
            if (sel == 0)
                burst = 16'd0;
            else if (sel == 1)
                burst = 16'hFFFF;
            else if (sel == 2)
                burst = 16'($urandom);
            else
            begin
                burst  = 16'($urandom_range(1, 5));
                budget += burst;
            end
            send_req(OP_LOAD, arr, prio, burst);
            if ($urandom_range(9) == 0)
                tick();
            if ($urandom_range(24) == 0)
                send_req(OP_UNUSED, 16'($urandom), 8'($urandom), 16'($urandom));
        end
        if (budget > 90)
            budget = 90;
        for (int i = 0; i < budget; i++)
        begin
            tick();
            // occasional late arrival into a running table
            if ($urandom_range(19) == 0)
                send_req(OP_LOAD, 16'($urandom_range(0, 40)), 8'($urandom),
                         16'($urandom_range(1, 4)));
            if ($urandom_range(29) == 0)
                send_req(OP_UNUSED, 16'($urandom), 8'($urandom), 16'($urandom));
        end
    endtask

    task automatic run_phase(input int sgap, input int rgap);
        int target;
        send_gap = sgap;
        recv_gap = rgap;
        target   = items_sent + PHASE_ITEMS;
        while (items_sent < target)
            run_schedule_batch();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, unused op, zero burst, field extremes, priority and tie order
        tick();
        send_req(OP_UNUSED, 16'hFFFF, 8'hFF, 16'hFFFF);
        send_req(OP_LOAD, 16'd0, 8'd255, 16'd0);
        tick();
        send_req(OP_LOAD, 16'd1, 8'd255, 16'd2);
        send_req(OP_LOAD, 16'd2, 8'd0, 16'd1);
        send_req(OP_LOAD, 16'hFFFF, 8'd0, 16'hFFFF);
        send_req(OP_LOAD, 16'd1, 8'd255, 16'd1);
        send_req(OP_LOAD, 16'd0, 8'd255, 16'd1);
        repeat (8) tick();
        send_req(OP_CLEAR, 16'hFFFF, 8'hFF, 16'hFFFF);
        tick();

        // Random traffic under three idling profiles
        run_phase(12, 79);
        run_phase(79, 12);
        stall_armed = 1'b1;
        run_phase(0, 0);

        @(negedge clk);
        req_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        $display("Run covered %0d requests and %0d checked responses: %0d completions, %0d idle",
                 items_sent, responses_seen, completions, idle_ticks);
        $display("ticks, with table overflow, zero bursts, priority ties and a long output stall.");
        if (mismatches == 0 && outstanding == 0)
            $display("preemptive_priority_scheduler_tb: PASS");
        else
            $display("preemptive_priority_scheduler_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
